// File: sv/scv_pkg.sv
// ----------------------------------------------------------------------------
// scv_pkg
// Shared constants, types and helper functions of the seeded chord voicing
// block and its 64-bit Mersenne twister.
// ----------------------------------------------------------------------------
package scv_pkg;

    localparam int unsigned MT_N     = 312;
    localparam int unsigned MT_M     = 156;
    localparam int unsigned MT_AW    = $clog2(MT_N);
    localparam int unsigned MT_WIDTH = 64;

    localparam logic [63:0] MT_MATRIX    = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] MT_UPPER     = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] MT_LOWER     = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] SEED_MULT    = 64'h5851_F42D_4C95_7F2D;
    localparam logic [63:0] DEFAULT_SEED = 64'd5489;

    localparam logic [6:0] BASE_NOTE = 7'd48;
    localparam logic [6:0] OCTAVE    = 7'd12;
    localparam logic [6:0] VEL_BASE  = 7'd50;

    // seeding sub-steps: three partial products, then the final add
    localparam logic [2:0] SUB_LAST = 3'd4;

    typedef enum logic [3:0] {
        ST_SEED0,
        ST_SEED,
        ST_IDLE,
        ST_DRAW_RD,
        ST_DRAW_SUM,
        ST_DRAW_MOD,
        ST_TW_START,
        ST_TW_FIRST,
        ST_TW_B,
        ST_TW_C,
        ST_EMIT
    } state_t;

    localparam logic [3:0] Q_MAJ  = 4'd0;
    localparam logic [3:0] Q_MIN  = 4'd1;
    localparam logic [3:0] Q_DOM7 = 4'd2;
    localparam logic [3:0] Q_M7   = 4'd3;
    localparam logic [3:0] Q_MAJ7 = 4'd4;
    localparam logic [3:0] Q_M7B5 = 4'd5;
    localparam logic [3:0] Q_DIM  = 4'd6;
    localparam logic [3:0] Q_DIM7 = 4'd7;

    // interval of chord tone n for quality q
    function automatic logic [3:0] interval_of(input logic [3:0] q, input logic [1:0] n);
        logic [15:0] row;
        begin
            unique case (q)
                Q_MIN:   row = {4'd0, 4'd7, 4'd3, 4'd0};
                Q_DOM7:  row = {4'd10, 4'd7, 4'd4, 4'd0};
                Q_M7:    row = {4'd10, 4'd7, 4'd3, 4'd0};
                Q_MAJ7:  row = {4'd11, 4'd7, 4'd4, 4'd0};
                Q_M7B5:  row = {4'd10, 4'd6, 4'd3, 4'd0};
                Q_DIM:   row = {4'd0, 4'd6, 4'd3, 4'd0};
                Q_DIM7:  row = {4'd9, 4'd6, 4'd3, 4'd0};
                default: row = {4'd0, 4'd7, 4'd4, 4'd0};
            endcase
            interval_of = row[{n, 2'b00} +: 4];
        end
    endfunction

    function automatic logic has_four(input logic [3:0] q);
        begin
            has_four = (q == Q_DOM7) || (q == Q_M7) || (q == Q_MAJ7) ||
                       (q == Q_M7B5) || (q == Q_DIM7);
        end
    endfunction

    function automatic logic [63:0] temper(input logic [63:0] w);
        logic [63:0] y;
        begin
            y = w;
            y = y ^ ((y >> 29) & 64'h5555_5555_5555_5555);
            y = y ^ ((y << 17) & 64'h71D6_7FFF_EDA6_0000);
            y = y ^ ((y << 37) & 64'hFFF7_EEE0_0000_0000);
            y = y ^ (y >> 43);
            temper = y;
        end
    endfunction

    // 256 = 1 mod 51, so the byte sum keeps the residue
    function automatic logic [10:0] byte_sum(input logic [63:0] y);
        logic [10:0] s;
        begin
            s = '0;
            for (int b = 0; b < 8; b++) begin
                s = s + {3'b000, y[8*b +: 8]};
            end
            byte_sum = s;
        end
    endfunction

    function automatic logic [5:0] mod51(input logic [10:0] s);
        logic [8:0] t;
        logic [5:0] r;
        begin
            t = {6'b0, s[10:8]} + {1'b0, s[7:0]};
            priority if (t >= 9'd255) r = 6'(t - 9'd255);
            else if (t >= 9'd204)     r = 6'(t - 9'd204);
            else if (t >= 9'd153)     r = 6'(t - 9'd153);
            else if (t >= 9'd102)     r = 6'(t - 9'd102);
            else if (t >= 9'd51)      r = 6'(t - 9'd51);
            else                      r = 6'(t);
            mod51 = r;
        end
    endfunction

    // 4 = 1 mod 3: add base-4 digits
    function automatic logic [1:0] mod3(input logic [5:0] r);
        logic [3:0] d;
        logic [3:0] m;
        begin
            d = {2'b00, r[5:4]} + {2'b00, r[3:2]} + {2'b00, r[1:0]};
            priority if (d >= 4'd6) m = d - 4'd6;
            else if (d >= 4'd3)     m = d - 4'd3;
            else                    m = d;
            mod3 = m[1:0];
        end
    endfunction

    // signed root reduced to 0..11
    function automatic logic [3:0] pitch_class(input logic signed [7:0] root);
        logic [8:0]  v;
        logic [14:0] p;
        logic [4:0]  q;
        logic [8:0]  r;
        begin
            v = 9'({root[7], root} + 9'sd132);
            p = 15'(v) * 15'd85;
            q = p[14:10];
            r = v - ({4'b0000, q} * 9'd12);
            if (r >= 9'd12) begin
                r = r - 9'd12;
            end
            pitch_class = r[3:0];
        end
    endfunction

endpackage

// File: sv/seeded_chord_voicing.sv
// ----------------------------------------------------------------------------
// seeded_chord_voicing
// Chord to note expander with a 64-bit Mersenne twister for inversion and
// velocity.
// ----------------------------------------------------------------------------
// One chord is taken at a time and gives 3 or 4 note transfers. A chord
// passes through an accept state, two twister draws (read, sum, reduce) and
// one emit per note, which out_ready can hold; its pace is set by the single
// read port of the 312-word twister RAM. The first chord after seeding and
// every 156th chord after it also regenerate the twister state in place, with
// two reads and one write per word. A chord with restart set first reseeds
// through the shared 32 x 32 multiplier, and its first draw then regenerates.
// After reset the same seeding pass runs with seed 5489, and in_ready stays
// low until it is done.
// ----------------------------------------------------------------------------
module seeded_chord_voicing (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               restart,
    input  logic [63:0]        seed,
    input  logic signed [7:0]  root_class,
    input  logic [3:0]         quality_code,
    input  logic [31:0]        chord_tick,
    input  logic [31:0]        duration,
    input  logic [3:0]         midi_channel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        note_on_tick,
    output logic [31:0]        note_off_tick,
    output logic [3:0]         out_channel,
    output logic [6:0]         note_number,
    output logic [6:0]         velocity,
    output logic               last_note
);

    localparam int unsigned AW = scv_pkg::MT_AW;
    localparam logic [AW-1:0] N_VAL    = AW'(scv_pkg::MT_N);
    localparam logic [AW-1:0] N_LAST   = AW'(scv_pkg::MT_N - 1);
    localparam logic [AW-1:0] M_VAL    = AW'(scv_pkg::MT_M);
    localparam logic [AW-1:0] NM_VAL   = AW'(scv_pkg::MT_N - scv_pkg::MT_M);

    scv_pkg::state_t state_reg, state_next;

    logic [63:0]   seed_reg;
    logic          seed_item_reg;
    logic [3:0]    pc_reg;
    logic [3:0]    q_reg;
    logic          four_reg;
    logic [31:0]   on_reg;
    logic [31:0]   off_reg;
    logic [3:0]    chan_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] cnt_reg;
    logic [2:0]    sub_reg;
    logic [63:0]   p_reg;
    logic [63:0]   acc_reg;
    logic [63:0]   prod_reg;
    logic [63:0]   cur_reg;
    logic [63:0]   nxt_reg;
    logic          draw_sel_reg;
    logic [10:0]   sum_reg;
    logic [1:0]    inv_reg;
    logic [6:0]    vel_reg;
    logic [1:0]    k_reg;
    logic          out_valid_reg;
    logic [31:0]   on_out_reg;
    logic [31:0]   off_out_reg;
    logic [3:0]    chan_out_reg;
    logic [6:0]    note_out_reg;
    logic [6:0]    vel_out_reg;
    logic          last_out_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;

    scv_ram #(
        .WIDTH (scv_pkg::MT_WIDTH),
        .DEPTH (scv_pkg::MT_N)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // seeding arithmetic
    logic [63:0] seed_x;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] seed_word;
    assign seed_x    = p_reg ^ (p_reg >> 62);
    assign mul_a     = (sub_reg == 3'd2) ? seed_x[63:32] : seed_x[31:0];
    assign mul_b     = (sub_reg == 3'd1) ? scv_pkg::SEED_MULT[63:32]
                                         : scv_pkg::SEED_MULT[31:0];
    assign seed_word = acc_reg + {{(64-AW){1'b0}}, cnt_reg};

    // twist arithmetic
    logic [63:0] tw_x;
    logic [63:0] tw_xa;
    logic [AW-1:0] addr_jm;
    logic [AW-1:0] addr_j2;
    assign tw_x    = (cur_reg & scv_pkg::MT_UPPER) | (nxt_reg & scv_pkg::MT_LOWER);
    assign tw_xa   = (tw_x >> 1) ^ (tw_x[0] ? scv_pkg::MT_MATRIX : 64'd0);
    assign addr_jm = (cnt_reg < NM_VAL) ? (cnt_reg + M_VAL) : (cnt_reg - NM_VAL);
    assign addr_j2 = (cnt_reg + AW'(2) == N_VAL) ? '0 : (cnt_reg + AW'(2));

    // draw reduction
    logic [5:0] r51;
    assign r51 = scv_pkg::mod51(sum_reg);

    // note of the current rotated position
    logic [2:0] rot_sum;
    logic [2:0] cnt3;
    logic       wrap;
    logic [1:0] src;
    logic [6:0] note_val;
    logic       k_last;
    logic       load_out;
    assign cnt3     = four_reg ? 3'd4 : 3'd3;
    assign rot_sum  = {1'b0, k_reg} + {1'b0, inv_reg};
    assign wrap     = (rot_sum >= cnt3);
    assign src      = wrap ? 2'(rot_sum - cnt3) : rot_sum[1:0];
    assign note_val = scv_pkg::BASE_NOTE + {3'b000, pc_reg}
                    + {3'b000, scv_pkg::interval_of(q_reg, src)}
                    - (wrap ? scv_pkg::OCTAVE : 7'd0);
    assign k_last   = ({1'b0, k_reg} == cnt3 - 3'd1);
    assign load_out = (state_reg == scv_pkg::ST_EMIT) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scv_pkg::ST_SEED0:
            begin
                state_next = scv_pkg::ST_SEED;
            end
            scv_pkg::ST_SEED:
            begin
                if (sub_reg == scv_pkg::SUB_LAST && cnt_reg == N_LAST)
                begin
                    state_next = seed_item_reg ? scv_pkg::ST_DRAW_RD : scv_pkg::ST_IDLE;
                end
            end
            scv_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = restart ? scv_pkg::ST_SEED0 : scv_pkg::ST_DRAW_RD;
                end
            end
            scv_pkg::ST_DRAW_RD:
            begin
                state_next = (idx_reg == N_VAL) ? scv_pkg::ST_TW_START
                                                : scv_pkg::ST_DRAW_SUM;
            end
            scv_pkg::ST_DRAW_SUM:
            begin
                state_next = scv_pkg::ST_DRAW_MOD;
            end
            scv_pkg::ST_DRAW_MOD:
            begin
                state_next = draw_sel_reg ? scv_pkg::ST_EMIT : scv_pkg::ST_DRAW_RD;
            end
            scv_pkg::ST_TW_START:
            begin
                state_next = scv_pkg::ST_TW_FIRST;
            end
            scv_pkg::ST_TW_FIRST:
            begin
                state_next = scv_pkg::ST_TW_B;
            end
            scv_pkg::ST_TW_B:
            begin
                state_next = scv_pkg::ST_TW_C;
            end
            scv_pkg::ST_TW_C:
            begin
                state_next = (cnt_reg == N_LAST) ? scv_pkg::ST_DRAW_RD : scv_pkg::ST_TW_B;
            end
            scv_pkg::ST_EMIT:
            begin
                if (load_out && k_last)
                begin
                    state_next = scv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scv_pkg::ST_IDLE;
            end
        endcase
    end

    // memory controls and handshake
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        in_ready  = 1'b0;
        unique case (state_reg)
            scv_pkg::ST_SEED0:
            begin
                ram_we    = 1'b1;
                ram_wdata = seed_reg;
            end
            scv_pkg::ST_SEED:
            begin
                ram_we    = (sub_reg == scv_pkg::SUB_LAST);
                ram_waddr = cnt_reg;
                ram_wdata = seed_word;
            end
            scv_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            scv_pkg::ST_DRAW_RD:
            begin
                ram_raddr = (idx_reg == N_VAL) ? '0 : idx_reg;
            end
            scv_pkg::ST_TW_FIRST:
            begin
                ram_raddr = AW'(1);
            end
            scv_pkg::ST_TW_B:
            begin
                ram_raddr = addr_jm;
            end
            scv_pkg::ST_TW_C:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = ram_rdata ^ tw_xa;
                ram_raddr = addr_j2;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scv_pkg::ST_SEED0;
            seed_reg      <= scv_pkg::DEFAULT_SEED;
            seed_item_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == scv_pkg::ST_IDLE && in_valid)
            begin
                seed_item_reg <= 1'b1;
                if (restart)
                begin
                    seed_reg <= seed;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            scv_pkg::ST_SEED0:
            begin
                p_reg   <= seed_reg;
                cnt_reg <= AW'(1);
                sub_reg <= '0;
            end
            scv_pkg::ST_SEED:
            begin
                prod_reg <= mul_a * mul_b;
                if (sub_reg == 3'd1)
                begin
                    acc_reg <= prod_reg;
                end
                else if (sub_reg == 3'd2 || sub_reg == 3'd3)
                begin
                    acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
                end
                if (sub_reg == scv_pkg::SUB_LAST)
                begin
                    p_reg   <= seed_word;
                    cnt_reg <= cnt_reg + AW'(1);
                    sub_reg <= '0;
                    idx_reg <= N_VAL;
                end
                else
                begin
                    sub_reg <= sub_reg + 3'd1;
                end
            end
            scv_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    pc_reg       <= scv_pkg::pitch_class(root_class);
                    q_reg        <= quality_code;
                    four_reg     <= scv_pkg::has_four(quality_code);
                    on_reg       <= chord_tick;
                    off_reg      <= chord_tick + duration;
                    chan_reg     <= midi_channel;
                    draw_sel_reg <= 1'b0;
                end
            end
            scv_pkg::ST_DRAW_RD:
            begin
                if (idx_reg != N_VAL)
                begin
                    idx_reg <= idx_reg + AW'(1);
                end
            end
            scv_pkg::ST_DRAW_SUM:
            begin
                sum_reg <= scv_pkg::byte_sum(scv_pkg::temper(ram_rdata));
            end
            scv_pkg::ST_DRAW_MOD:
            begin
                if (!draw_sel_reg)
                begin
                    inv_reg      <= scv_pkg::mod3(r51);
                    draw_sel_reg <= 1'b1;
                end
                else
                begin
                    vel_reg <= scv_pkg::VEL_BASE + {1'b0, r51};
                    k_reg   <= '0;
                end
            end
            scv_pkg::ST_TW_START:
            begin
                cnt_reg <= '0;
            end
            scv_pkg::ST_TW_FIRST:
            begin
                cur_reg <= ram_rdata;
            end
            scv_pkg::ST_TW_B:
            begin
                nxt_reg <= ram_rdata;
            end
            scv_pkg::ST_TW_C:
            begin
                cur_reg <= nxt_reg;
                cnt_reg <= cnt_reg + AW'(1);
                if (cnt_reg == N_LAST)
                begin
                    idx_reg <= '0;
                end
            end
            scv_pkg::ST_EMIT:
            begin
                if (load_out)
                begin
                    on_out_reg   <= on_reg;
                    off_out_reg  <= off_reg;
                    chan_out_reg <= chan_reg;
                    note_out_reg <= note_val;
                    vel_out_reg  <= vel_reg;
                    last_out_reg <= k_last;
                    k_reg        <= k_reg + 2'd1;
                end
            end
            default:
            begin
                sub_reg <= sub_reg;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign note_on_tick  = on_out_reg;
    assign note_off_tick = off_out_reg;
    assign out_channel   = chan_out_reg;
    assign note_number   = note_out_reg;
    assign velocity      = vel_out_reg;
    assign last_note     = last_out_reg;

endmodule

// File: sv/scv_ram.sv
// ----------------------------------------------------------------------------
// scv_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module scv_ram #(
    parameter int unsigned WIDTH = scv_pkg::MT_WIDTH,
    parameter int unsigned DEPTH = scv_pkg::MT_N
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/scv_checker.sv
// ----------------------------------------------------------------------------
// scv_checker
// Port-level checks of the seeded chord voicing block.
// ----------------------------------------------------------------------------
module scv_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [31:0]        note_on_tick,
    input logic [6:0]         note_number,
    input logic [6:0]         velocity,
    input logic               last_note
);

    // stalled note holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(note_number) &&
        $stable(velocity) && $stable(last_note) && $stable(note_on_tick))
        else $error("stalled note changed");

    a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> velocity >= 7'd50 && velocity <= 7'd100)
        else $error("velocity out of range");

    a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> note_number >= 7'd36 && note_number <= 7'd70)
        else $error("note out of range");

    // a new chord is only taken once the previous one is down to its last note
    a_chord_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last_note)
        else $error("chord accepted while notes remain");

endmodule

bind seeded_chord_voicing scv_checker u_scv_checker (.*);
